// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the keyword scorer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define KWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kws_pkg.sv =====
// Types and constants of the keyword weight scorer.
`default_nettype none

package kws_pkg;

  localparam int KwCount  = 6;
  localparam int WinBytes = 7;
  localparam int WinW     = 8 * WinBytes;
  localparam int CfgIdxW  = 1;
  localparam int ConfW    = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAuthConf = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSensConf = 1'b1;

  localparam logic [ConfW-1:0] AuthConfReset = 7'd85;
  localparam logic [ConfW-1:0] SensConfReset = 7'd90;

  // Keyword text right-aligned: the final character sits in bits [7:0].
  // Order: sudo, admin, please, delete, password, db_drop.
  localparam logic [63:0] KwText [KwCount] = '{
    64'h0000_0000_7375_646f,
    64'h0000_0061_646d_696e,
    64'h0000_706c_6561_7365,
    64'h0000_6465_6c65_7465,
    64'h7061_7373_776f_7264,
    64'h0064_625f_6472_6f70
  };

  localparam logic [63:0] KwMask [KwCount] = '{
    64'h0000_0000_ffff_ffff,
    64'h0000_00ff_ffff_ffff,
    64'h0000_ffff_ffff_ffff,
    64'h0000_ffff_ffff_ffff,
    64'hffff_ffff_ffff_ffff,
    64'h00ff_ffff_ffff_ffff
  };

  localparam logic signed [7:0] KwWeight [KwCount] = '{
    8'sd50, 8'sd30, -8'sd20, 8'sd40, 8'sd70, 8'sd90
  };

  // Set bits mark authority keywords; the others are sensitivity keywords.
  localparam logic [KwCount-1:0] KwIsAuth = 6'b000111;

  localparam logic signed [9:0] AuthMax  = 10'sd100;
  localparam logic signed [9:0] AuthMin  = -10'sd100;
  localparam logic [8:0]        SensBase = 9'd10;
  localparam logic [8:0]        SensMax  = 9'd100;

  typedef logic [KwCount-1:0] kw_flags_t;

  typedef struct packed {
    logic signed [7:0] authority;
    logic [6:0]        sensitivity;
    logic [ConfW-1:0]  authority_conf_out;
    logic [ConfW-1:0]  sensitivity_conf_out;
  } kws_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kws_byte_if.sv =====
// Input channel carrying one payload byte per transaction.
`default_nettype none

interface kws_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kws_result_if.sv =====
// Output channel carrying one score result per transaction.
`default_nettype none

interface kws_result_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] authority;
  logic [6:0]        sensitivity;
  logic [6:0]        authority_conf_out;
  logic [6:0]        sensitivity_conf_out;

  modport source (output valid, output authority, output sensitivity,
                  output authority_conf_out, output sensitivity_conf_out, input ready);
  modport sink (input valid, input authority, input sensitivity,
                input authority_conf_out, input sensitivity_conf_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kws_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface kws_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kws_matcher.sv =====
// Case folding, recent byte window and keyword seen flags.
`default_nettype none

module kws_matcher
  import kws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output kw_flags_t       seen_o
);

  `include "assert_macros.svh"

  logic [WinW-1:0] recent_q, recent_d;
  kw_flags_t       seen_q, seen_d;
  logic [7:0]      cur;
  logic [63:0]     win;
  kw_flags_t       hits;

  always_comb begin
    if (byte_i inside {[8'h41:8'h5a]}) begin
      cur = byte_i + 8'h20;
    end else begin
      cur = byte_i;
    end
  end

  // Newest byte in the low lane, oldest window byte in the high lane.
  assign win = {recent_q, cur};

  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      hits[k] = ((win ^ KwText[k]) & KwMask[k]) == 64'h0;
    end
  end

  assign seen_o = seen_q | hits;

  always_comb begin
    recent_d = recent_q;
    seen_d   = seen_q;
    if (step_i) begin
      if (last_i) begin
        recent_d = '0;
        seen_d   = '0;
      end else begin
        recent_d = win[WinW-1:0];
        seen_d   = seen_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      seen_q   <= '0;
    end else begin
      recent_q <= recent_d;
      seen_q   <= seen_d;
    end
  end

  `KWS_ASSERT_NEXT(a_clear_after_last, step_i && last_i,
                   recent_q == '0 && seen_q == '0, "window not cleared after last byte")
  `KWS_ASSERT_NEXT(a_flags_sticky, !(step_i && last_i),
                   (seen_q & $past(seen_q)) == $past(seen_q), "seen flag dropped mid payload")

endmodule

`default_nettype wire

// ===== hw/rtl/kws_score.sv =====
// Weight sums and clamping of the authority and sensitivity scores.
`default_nettype none

module kws_score
  import kws_pkg::*;
(
  input  wire kw_flags_t         seen_i,
  input  wire logic [ConfW-1:0]  auth_level_i,
  input  wire logic [ConfW-1:0]  sens_level_i,
  output kws_result_t            result_o
);

  logic signed [9:0] auth_sum;
  logic [8:0]        sens_sum;
  logic signed [9:0] auth_clamped;
  logic [8:0]        sens_clamped;

  always_comb begin
    auth_sum = '0;
    sens_sum = SensBase;
    for (int k = 0; k < KwCount; k++) begin
      if (seen_i[k]) begin
        if (KwIsAuth[k]) begin
          auth_sum = auth_sum + 10'(KwWeight[k]);
        end else begin
          sens_sum = sens_sum + 9'(unsigned'(KwWeight[k]));
        end
      end
    end
  end

  always_comb begin
    if (auth_sum > AuthMax) begin
      auth_clamped = AuthMax;
    end else if (auth_sum < AuthMin) begin
      auth_clamped = AuthMin;
    end else begin
      auth_clamped = auth_sum;
    end
    if (sens_sum > SensMax) begin
      sens_clamped = SensMax;
    end else begin
      sens_clamped = sens_sum;
    end
  end

  assign result_o.authority            = auth_clamped[7:0];
  assign result_o.sensitivity          = sens_clamped[6:0];
  assign result_o.authority_conf_out   = auth_level_i;
  assign result_o.sensitivity_conf_out = sens_level_i;

endmodule

`default_nettype wire

// ===== hw/rtl/keyword_weight_scorer_core.sv =====
// Top level of the keyword weight scorer.
`default_nettype none

// The scorer takes a text payload one byte per transaction on byte_i, folds
// ASCII capitals to lower case, and watches for six keywords ("sudo",
// "admin", "please", "delete", "password", "db_drop") ending on each byte.
// When the byte marked last_byte is processed, one transaction appears on
// result_o: the authority score (sum of the authority keyword weights,
// clamped to -100..100), the sensitivity score (10 plus the sensitivity
// keyword weights, capped at 100), and copies of the two confidence
// registers. All scores are in hundredths. The keyword window and the seen
// flags clear after every last byte, so payloads never affect each other;
// an empty payload is sent as a single zero byte with last_byte set.
// Timing: one byte is accepted every clock cycle while byte_i.ready is high.
// A byte is captured in an input register and matched and scored from there;
// the score of a last byte is then held in the result register, which drives
// result_o. The result register decouples the two sides, so ordinary bytes
// keep flowing while a result waits; only when the next last byte sits in
// the input register and would overwrite the waiting result does
// byte_i.ready drop. Configuration writes on cfg_i are always accepted
// and should be issued only while no payload is in flight.
module keyword_weight_scorer_core
  import kws_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  kws_byte_if.sink      byte_i,
  kws_result_if.source  result_o,
  kws_cfg_if.sink       cfg_i
);

  `include "assert_macros.svh"

  // Input register stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Result register stage.
  logic        out_valid_q;
  kws_result_t out_res_q;
  kws_result_t res_d;

  logic [ConfW-1:0] auth_level_q;
  logic [ConfW-1:0] sens_level_q;

  logic      advance;
  logic      in_take;
  logic      step;
  kw_flags_t seen;

  // The result register can take a new score when it is empty or drained
  // in this cycle. Bytes that do not close a payload never touch it, so
  // they move on regardless; a last byte waits until the register is free.
  assign advance      = !out_valid_q || result_o.ready;
  assign step         = s1_valid_q && (!s1_last_q || advance);
  assign byte_i.ready = !s1_valid_q || step;
  assign in_take      = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= byte_i.byte_value;
      s1_last_q <= byte_i.last_byte;
    end
  end

  kws_matcher u_matcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .seen_o (seen)
  );

  kws_score u_score (
    .seen_i       (seen),
    .auth_level_i (auth_level_q),
    .sens_level_i (sens_level_q),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_last_q) begin
      out_res_q <= res_d;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.authority            = out_res_q.authority;
  assign result_o.sensitivity          = out_res_q.sensitivity;
  assign result_o.authority_conf_out   = out_res_q.authority_conf_out;
  assign result_o.sensitivity_conf_out = out_res_q.sensitivity_conf_out;

  // Configuration registers; writes complete in the cycle they are presented.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_level_q <= AuthConfReset;
      sens_level_q <= SensConfReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgAuthConf: auth_level_q <= cfg_i.data;
        CfgSensConf: sens_level_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  `KWS_ASSERT_NEXT(a_last_gives_result, step && s1_last_q, out_valid_q,
                   "processed last byte produced no result")
  `KWS_ASSERT_IMP(a_auth_range, out_valid_q,
                  out_res_q.authority <= 8'sd100 && out_res_q.authority >= -8'sd100,
                  "authority score out of range")
  `KWS_ASSERT_IMP(a_sens_range, out_valid_q,
                  out_res_q.sensitivity >= 7'd10 && out_res_q.sensitivity <= 7'd100,
                  "sensitivity score out of range")
  `KWS_ASSERT_IMP(a_no_overwrite, out_valid_q && !result_o.ready, !(step && s1_last_q),
                  "pending result would be overwritten")

endmodule

`default_nettype wire
